// ===== rtl/core/sstg_pkg.sv =====
// Package: shared types, constants and state encoding for the trajectory generator.
package sstg_pkg;

    localparam int MAX_STEPS_DEF = 64;
    localparam logic [31:0] MIN_SEG_US = 32'd100000;

    typedef enum logic [1:0] {
        CFG_STEP_TIME = 2'd0,
        CFG_BOOM_INV  = 2'd1,
        CFG_ARM_INV   = 2'd2,
        CFG_BKT_INV   = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUR,
        ST_NDIV,
        ST_NFIX,
        ST_TDIV,
        ST_SQ,
        ST_CUBE,
        ST_SMUL,
        ST_JMUL,
        ST_GAP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;       // capture input item
        logic first;      // emit the start point
        logic dur;        // compute segment duration
        logic ndiv_start; // start n = dur / dt
        logic nfix;       // clamp n
        logic tdiv_start; // start t = i*65536 / n
        logic sq;
        logic cube;
        logic smul;
        logic jmul;
        logic gap;
        logic emit;       // load output register, advance
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic first_item;
        logic last_point;
        logic out_full;
    } sts_t;

endpackage

// ===== rtl/core/sstg_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module sstg_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [35:0] dividend,
    input  logic [31:0] divisor,
    output logic [35:0] quotient,
    output logic        busy
);
    import sstg_pkg::*;

    logic [35:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[31:0], q_reg[35]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd36;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[34:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[34:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    assign quotient = q_reg;
    assign busy     = busy_reg;
endmodule

// ===== rtl/core/sstg_datapath.sv =====
// Datapath: config registers, waypoint state, interpolation arithmetic, output register.
module sstg_datapath
#(
    parameter int MAX_STEPS = sstg_pkg::MAX_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [19:0]        cfg_data,
    input  logic               first_waypoint,
    input  logic signed [15:0] boom_angle,
    input  logic signed [15:0] arm_angle,
    input  logic signed [15:0] bucket_angle,
    input  sstg_pkg::cmd_t     cmd,
    output sstg_pkg::sts_t     sts,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [31:0]        time_us,
    output logic signed [15:0] boom_out,
    output logic signed [15:0] arm_out,
    output logic signed [15:0] bucket_out,
    output logic               last_of_run,
    output logic               steps_clipped
);
    import sstg_pkg::*;

    localparam int NW = $clog2(MAX_STEPS + 1);

    logic [19:0] dt_reg;
    logic [15:0] inv_reg [3];
    logic signed [15:0] last_reg [3];
    logic signed [15:0] tgt_reg [3];
    logic signed [15:0] prev_reg [3];
    logic signed [15:0] cur_reg [3];
    logic [16:0] mag_reg [3];
    logic        neg_reg [3];
    logic [31:0] last_time_reg;
    logic [32:0] time_reg;
    logic        started_reg;
    logic        firstin_reg;
    logic [31:0] dur_reg;
    logic [NW-1:0] n_reg, i_reg;
    logic        clip_reg;
    logic [16:0] t_reg;
    logic [33:0] tt_reg;
    logic [50:0] ttt_reg;
    logic [16:0] s_reg;
    logic [31:0] g_reg [3];
    logic [1:0]  j_reg;

    logic        div_start, div_busy;
    logic [35:0] div_dvd, div_q;
    logic [31:0] div_dvs;
    logic [19:0] dt_eff;
    logic [51:0] q48;
    logic [33:0] sm;
    logic [16:0] qv;
    logic signed [17:0] curw;
    logic [31:0] gmax;
    logic [32:0] time_sum, time_new;

    assign dt_eff = (dt_reg == 20'd0) ? 20'd1 : dt_reg;
    assign div_start = cmd.ndiv_start | cmd.tdiv_start;
    assign div_dvd = cmd.ndiv_start ? {4'd0, dur_reg}
                                    : {{(36-NW-16){1'b0}}, i_reg, 16'd0};
    assign div_dvs = cmd.ndiv_start ? {12'd0, dt_eff} : {{(32-NW){1'b0}}, n_reg};

    sstg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .busy     (div_busy)
    );

    // 3t^2*2^16 - 2t^3, rounded from Q48 to Q16
    assign q48 = 52'({tt_reg, 17'd0}) + 52'({tt_reg, 16'd0}) - {ttt_reg, 1'b0};
    assign sm  = s_reg * mag_reg[j_reg];
    assign qv  = 17'((sm + 34'd32768) >> 16);
    assign curw = neg_reg[j_reg] ? 18'(last_reg[j_reg]) - 18'(signed'({1'b0, qv}))
                                 : 18'(last_reg[j_reg]) + 18'(signed'({1'b0, qv}));

    always_comb
    begin
        gmax = {12'd0, dt_eff};
        for (int j = 0; j < 3; j++)
            if (g_reg[j] > gmax)
                gmax = g_reg[j];
    end

    // next point time, saturating
    assign time_sum = time_reg + {1'b0, gmax};
    assign time_new = time_sum[32] ? 33'h0FFFFFFFF : time_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg        <= 20'd10000;
            inv_reg[0]    <= 16'd488;
            inv_reg[1]    <= 16'd488;
            inv_reg[2]    <= 16'd488;
            last_reg[0]   <= '0;
            last_reg[1]   <= '0;
            last_reg[2]   <= '0;
            last_time_reg <= '0;
            started_reg   <= 1'b0;
            out_valid     <= 1'b0;
            j_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_STEP_TIME: dt_reg     <= cfg_data;
                    CFG_BOOM_INV:  inv_reg[0] <= cfg_data[15:0];
                    CFG_ARM_INV:   inv_reg[1] <= cfg_data[15:0];
                    CFG_BKT_INV:   inv_reg[2] <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.first || cmd.emit)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cmd.first)
            begin
                for (int j = 0; j < 3; j++)
                    last_reg[j] <= tgt_reg[j];
                last_time_reg <= '0;
                started_reg   <= 1'b1;
            end
            if (cmd.jmul)
                j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
            if (cmd.emit && (i_reg == n_reg))
            begin
                for (int j = 0; j < 3; j++)
                    last_reg[j] <= cur_reg[j];
                last_time_reg <= time_new[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tgt_reg[0]  <= boom_angle;
            tgt_reg[1]  <= arm_angle;
            tgt_reg[2]  <= bucket_angle;
            firstin_reg <= first_waypoint;
        end
        if (cmd.first)
        begin
            time_us       <= '0;
            boom_out      <= tgt_reg[0];
            arm_out       <= tgt_reg[1];
            bucket_out    <= tgt_reg[2];
            last_of_run   <= 1'b1;
            steps_clipped <= 1'b0;
        end
        if (cmd.dur)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic signed [16:0] d;
                d = 17'(tgt_reg[j]) - 17'(last_reg[j]);
                neg_reg[j]  <= d[16];
                mag_reg[j]  <= d[16] ? 17'(-d) : 17'(d);
                prev_reg[j] <= last_reg[j];
            end
            // reuse g for |delta|*inv, max taken in ST_NDIV entry
            for (int j = 0; j < 3; j++)
                g_reg[j] <= 32'(17'(tgt_reg[j] > last_reg[j] ? tgt_reg[j] - last_reg[j]
                            : last_reg[j] - tgt_reg[j]) * inv_reg[j]);
            time_reg <= {1'b0, last_time_reg};
            i_reg    <= NW'(1);
        end
        if (cmd.nfix)
        begin
            if (div_q == 36'd0)
            begin
                n_reg    <= NW'(1);
                clip_reg <= 1'b0;
            end
            else if (div_q > 36'(MAX_STEPS))
            begin
                n_reg    <= NW'(MAX_STEPS);
                clip_reg <= 1'b1;
            end
            else
            begin
                n_reg    <= div_q[NW-1:0];
                clip_reg <= 1'b0;
            end
        end
        if (cmd.sq)
        begin
            t_reg  <= div_q[16:0];
            tt_reg <= div_q[16:0] * div_q[16:0];
        end
        if (cmd.cube)
            ttt_reg <= tt_reg * t_reg;
        if (cmd.smul)
            s_reg <= 17'((q48 + 52'h80000000) >> 32);
        if (cmd.jmul)
            cur_reg[j_reg] <= curw[15:0];
        if (cmd.gap)
            for (int j = 0; j < 3; j++)
                g_reg[j] <= 32'(17'(cur_reg[j] > prev_reg[j] ? cur_reg[j] - prev_reg[j]
                            : prev_reg[j] - cur_reg[j]) * inv_reg[j]);
        if (cmd.emit)
        begin
            time_reg      <= time_new;
            time_us       <= time_new[31:0];
            boom_out      <= cur_reg[0];
            arm_out       <= cur_reg[1];
            bucket_out    <= cur_reg[2];
            last_of_run   <= (i_reg == n_reg);
            steps_clipped <= clip_reg;
            for (int j = 0; j < 3; j++)
                prev_reg[j] <= cur_reg[j];
            i_reg <= i_reg + NW'(1);
        end
    end

    // duration = max(100000, |delta|*inv)
    logic [31:0] dur_max;
    always_comb
    begin
        dur_max = MIN_SEG_US;
        for (int j = 0; j < 3; j++)
            if (g_reg[j] > dur_max)
                dur_max = g_reg[j];
    end

    // dur_reg is refreshed in the cycle after the products land
    logic dur_pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dur_pend_reg <= 1'b0;
        else
            dur_pend_reg <= cmd.dur;
    end

    logic [31:0] dur_sel;
    assign dur_sel = dur_pend_reg ? dur_max : dur_reg;

    assign sts.div_busy   = div_busy;
    assign sts.first_item = firstin_reg | ~started_reg;
    assign sts.last_point = (i_reg == n_reg);
    assign sts.out_full   = out_valid & ~out_ready;

    // dividend for n uses the freshly computed duration
    always_ff @(posedge clk)
    begin
        if (dur_pend_reg)
            dur_reg <= dur_sel;
    end
endmodule

// ===== rtl/core/sstg_ctrl.sv =====
// Controller: sequences waypoint setup and per-point interpolation.
module sstg_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sstg_pkg::sts_t sts,
    output sstg_pkg::cmd_t cmd
);
    import sstg_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DUR;
                end
            end
            ST_DUR:
            begin
                if (sts.first_item)
                begin
                    if (!sts.out_full)
                    begin
                        cmd.first  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.dur    = 1'b1;
                    k_next     = 2'd0;
                    state_next = ST_NDIV;
                end
            end
            ST_NDIV:
            begin
                // wait for the duration max to register in dur_reg
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd1)
                begin
                    cmd.ndiv_start = 1'b1;
                    state_next     = ST_NFIX;
                end
            end
            ST_NFIX:
            begin
                if (!sts.div_busy)
                begin
                    cmd.nfix   = 1'b1;
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                cmd.tdiv_start = 1'b1;
                state_next     = ST_SQ;
            end
            ST_SQ:
            begin
                if (!sts.div_busy)
                begin
                    cmd.sq     = 1'b1;
                    state_next = ST_CUBE;
                end
            end
            ST_CUBE:
            begin
                cmd.cube   = 1'b1;
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                cmd.smul   = 1'b1;
                k_next     = 2'd0;
                state_next = ST_JMUL;
            end
            ST_JMUL:
            begin
                cmd.jmul = 1'b1;
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd2)
                    state_next = ST_GAP;
            end
            ST_GAP:
            begin
                cmd.gap    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last_point ? ST_IDLE : ST_TDIV;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/smoothstep_joint_trajectory_generator.sv =====
// Smoothstep joint trajectory generator for a boom, arm and bucket.
//
// Input channel (in_valid/in_ready) takes one waypoint item. A first
// waypoint, or any waypoint before one, yields a single point at time zero.
// Every other waypoint yields n = clamp(duration/step_time, 1, MAX_STEPS)
// points on the output channel (out_valid/out_ready), the last flagged.
// Setup computes the segment duration and divides it by step_time for n;
// each point then runs the shared 36-step serial divider for t = i/n,
// then square, cube, smoothstep and three joint multiplies. One item is
// worked on at a time; in_ready is high only between items.
// The output register holds a point until taken; when out_ready is low the
// sequencer waits before overwriting it.
// Reset restores the register defaults and clears joint history and time.
// Config writes (cfg_we/cfg_addr/cfg_data) must be issued while idle.
module smoothstep_joint_trajectory_generator
#(
    parameter int MAX_STEPS = sstg_pkg::MAX_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [19:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               first_waypoint,
    input  logic signed [15:0] boom_angle,
    input  logic signed [15:0] arm_angle,
    input  logic signed [15:0] bucket_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        time_us,
    output logic signed [15:0] boom_out,
    output logic signed [15:0] arm_out,
    output logic signed [15:0] bucket_out,
    output logic               last_of_run,
    output logic               steps_clipped
);
    import sstg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sstg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sstg_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .first_waypoint (first_waypoint),
        .boom_angle     (boom_angle),
        .arm_angle      (arm_angle),
        .bucket_angle   (bucket_angle),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .time_us        (time_us),
        .boom_out       (boom_out),
        .arm_out        (arm_out),
        .bucket_out     (bucket_out),
        .last_of_run    (last_of_run),
        .steps_clipped  (steps_clipped)
    );
endmodule

// ===== rtl/core/sstg_checker.sv =====
// Port-level checker for the trajectory generator, bound to the top level.
module sstg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] time_us,
    input logic        last_of_run,
    input logic        steps_clipped
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(time_us))
        else $error("output item changed while stalled");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting an item");

    a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> time_us >= $past(time_us))
        else $error("time went backward inside a run");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(last_of_run) && $stable(steps_clipped))
        else $error("output flags changed while stalled");
endmodule

bind smoothstep_joint_trajectory_generator sstg_checker u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .time_us       (time_us),
    .last_of_run   (last_of_run),
    .steps_clipped (steps_clipped)
);
